FILE: src/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

   localparam int OPERAND_WIDTH = 32;
   localparam int WIDE_WIDTH = 64;
   localparam int CNT_WIDTH = 7;

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_SUB = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;
   localparam logic [1:0] MODE_DIV = 2'd3;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic signed [31:0] num_a;
      logic signed [31:0] den_a;
      logic signed [31:0] num_b;
      logic signed [31:0] den_b;
   } req_type;

   typedef struct packed {
      logic signed [63:0] num_r;
      logic [62:0] den_r;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_CHECK,
      ST_GCD_START,
      ST_GCD_WAIT,
      ST_DIVN_START,
      ST_DIVN_WAIT,
      ST_DIVD_START,
      ST_DIVD_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic done;
      logic [63:0] quotient;
      logic [63:0] remainder;
   } div_res_type;

   function automatic logic signed [63:0] sext_operand(input logic [31:0] v);
      logic signed [OPERAND_WIDTH-1:0] low;
      begin
         low = v[OPERAND_WIDTH-1:0];
         return WIDE_WIDTH'(low);
      end
   endfunction

endpackage

FILE: src/rau_divider.sv
// Shared radix-2 restoring divider, 64-bit unsigned, one quotient bit per cycle.
module rau_divider (
   input  logic clock,
   input  logic reset,
   input  rau_pkg::div_cmd_type cmd,
   output rau_pkg::div_res_type res
);
   import rau_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dsr_ff, dsr_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [64:0] trial;
   logic [64:0] shifted;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[63]};
      trial = shifted - {1'b0, dsr_ff};
      if (cmd.start) begin
         quo_in = cmd.dividend;
         rem_in = '0;
         dsr_in = cmd.divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_WIDTH'(WIDE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign res.done = done_ff;
   assign res.quotient = quo_ff;
   assign res.remainder = rem_ff;

endmodule

FILE: src/rau_gcd.sv
// Euclidean GCD sequencer built on the shared divider.
module rau_gcd (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [63:0] x,
   input  logic [63:0] y,
   input  rau_pkg::div_res_type div_res,
   output rau_pkg::div_cmd_type div_cmd,
   output logic done,
   output logic [63:0] gcd
);
   import rau_pkg::*;

   logic [63:0] x_ff, x_in;
   logic [63:0] y_ff, y_in;
   logic run_ff, run_in;
   logic wait_ff, wait_in;
   logic done_ff, done_in;

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      run_in = run_ff;
      wait_in = wait_ff;
      done_in = 1'b0;
      div_cmd.start = 1'b0;
      div_cmd.dividend = x_ff;
      div_cmd.divisor = y_ff;
      if (start) begin
         x_in = x;
         y_in = y;
         run_in = 1'b1;
         wait_in = 1'b0;
      end else if (run_ff && !wait_ff) begin
         if (y_ff == '0) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end else begin
            div_cmd.start = 1'b1;
            wait_in = 1'b1;
         end
      end else if (run_ff && div_res.done) begin
         x_in = y_ff;
         y_in = div_res.remainder;
         wait_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      if (reset) begin
         run_ff <= 1'b0;
         wait_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         wait_ff <= wait_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign gcd = x_ff;

endmodule

FILE: src/rational_arith_unit_core.sv
// Top level of the rational arithmetic unit: sequencer, multiplier and result.
//
// Usage: drive req_data and pulse start while busy is low; the beat is taken
// at that edge and busy rises on the next cycle. Operands are OPERAND_WIDTH-bit
// two's complement values. The result appears on rsp_data for exactly one
// cycle with rsp_valid high; the receiver cannot stall it and must take it.
// Steps: cross products in ST_MUL0, ST_MUL1 and ST_MUL2 on one shared 32x32
// multiplier, the ST_CHECK state, then a Euclidean GCD on the shared 64-bit
// divider (one division per remainder step), then two divisions by the GCD.
// A zero numerator or an error skips the GCD and goes from ST_CHECK straight
// to ST_DONE. One item at a time; busy stays high until the result beat, and
// a new beat can be taken at the end of the result cycle.
// Reset clears the sequencer; the block is idle and ready after it.
module rational_arith_unit_core (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  rau_pkg::req_type req_data,
   output logic rsp_valid,
   output rau_pkg::rsp_type rsp_data
);
   import rau_pkg::*;

   state_type state_ff, state_in;
   req_type req_ff;
   logic [63:0] p_ff, p_in, q_ff, q_in, d_ff, d_in;
   logic [63:0] m_ff, m_in, e_ff, e_in, g_ff, g_in;
   logic neg_ff, neg_in;
   logic [1:0] mstep_ff, mstep_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [63:0] na, da, nb, db;
   logic signed [31:0] mul_x, mul_y;
   logic signed [63:0] mul_p;
   logic [63:0] n_sum;
   logic ovf;

   div_cmd_type gcd_cmd, div_cmd;
   div_res_type div_res;
   logic gcd_start, gcd_done;
   logic [63:0] gcd_val;

   rau_divider u_div (.clock(clock), .reset(reset), .cmd(div_cmd), .res(div_res));

   rau_gcd u_gcd (
      .clock(clock), .reset(reset), .start(gcd_start), .x(m_ff), .y(e_ff),
      .div_res(div_res), .div_cmd(gcd_cmd), .done(gcd_done), .gcd(gcd_val)
   );

   always_comb begin
      na = sext_operand(req_ff.num_a);
      da = sext_operand(req_ff.den_a);
      nb = sext_operand(req_ff.num_b);
      db = sext_operand(req_ff.den_b);
      unique case (mstep_ff)
         2'd0: begin
            mul_x = na[31:0];
            mul_y = (req_ff.mode == MODE_MUL) ? nb[31:0] : db[31:0];
         end
         2'd1: begin
            mul_x = da[31:0];
            mul_y = (req_ff.mode == MODE_MUL) ? db[31:0] : nb[31:0];
         end
         default: begin
            mul_x = da[31:0];
            mul_y = db[31:0];
         end
      endcase
      mul_p = mul_x * mul_y;
      if (req_ff.mode == MODE_ADD) begin
         n_sum = p_ff + q_ff;
         ovf = ((p_ff ^ n_sum) & (q_ff ^ n_sum)) >> 63 != 0;
      end else begin
         n_sum = p_ff - q_ff;
         ovf = ((p_ff ^ q_ff) & (p_ff ^ n_sum)) >> 63 != 0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_MUL0;
         ST_MUL0: state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_CHECK;
         ST_CHECK: begin
            if (da == 0 || db == 0 || d_ff == 0) state_in = ST_DONE;
            else if ((req_ff.mode == MODE_ADD || req_ff.mode == MODE_SUB) && ovf)
               state_in = ST_DONE;
            else if (((req_ff.mode == MODE_ADD || req_ff.mode == MODE_SUB) ? n_sum : p_ff)
                     == 0)
               state_in = ST_DONE;
            else state_in = ST_GCD_START;
         end
         ST_GCD_START: state_in = ST_GCD_WAIT;
         ST_GCD_WAIT: if (gcd_done) state_in = ST_DIVN_START;
         ST_DIVN_START: state_in = ST_DIVN_WAIT;
         ST_DIVN_WAIT: if (div_res.done) state_in = ST_DIVD_START;
         ST_DIVD_START: state_in = ST_DIVD_WAIT;
         ST_DIVD_WAIT: if (div_res.done) state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic [63:0] n_val;
      p_in = p_ff;
      q_in = q_ff;
      d_in = d_ff;
      m_in = m_ff;
      e_in = e_ff;
      g_in = g_ff;
      neg_in = neg_ff;
      mstep_in = mstep_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = 1'b0;
      gcd_start = 1'b0;
      div_cmd = gcd_cmd;
      n_val = (req_ff.mode == MODE_ADD || req_ff.mode == MODE_SUB) ? n_sum : p_ff;
      unique case (state_ff)
         ST_IDLE: mstep_in = 2'd0;
         ST_MUL0: begin
            p_in = mul_p;
            mstep_in = 2'd1;
         end
         ST_MUL1: begin
            q_in = mul_p;
            mstep_in = 2'd2;
         end
         ST_MUL2: d_in = (req_ff.mode == MODE_DIV) ? q_ff : mul_p;
         ST_CHECK: begin
            rsp_in = '0;
            neg_in = n_val[63] ^ d_ff[63];
            m_in = n_val[63] ? 64'(0) - n_val : n_val;
            e_in = d_ff[63] ? 64'(0) - d_ff : d_ff;
            if (da == 0 || db == 0 || d_ff == 0) rsp_in.status = STATUS_ZERO_DEN;
            else if ((req_ff.mode == MODE_ADD || req_ff.mode == MODE_SUB) && ovf)
               rsp_in.status = STATUS_OVERFLOW;
            else if (n_val == 0) rsp_in.den_r = 63'd1;
         end
         ST_GCD_START: gcd_start = 1'b1;
         ST_GCD_WAIT: g_in = gcd_val;
         ST_DIVN_START: begin
            div_cmd.start = 1'b1;
            div_cmd.dividend = m_ff;
            div_cmd.divisor = g_ff;
         end
         ST_DIVN_WAIT: if (div_res.done) m_in = div_res.quotient;
         ST_DIVD_START: begin
            div_cmd.start = 1'b1;
            div_cmd.dividend = e_ff;
            div_cmd.divisor = g_ff;
         end
         ST_DIVD_WAIT: begin
            if (div_res.done) begin
               if (!neg_ff && m_ff[63]) begin
                  rsp_in.status = STATUS_OVERFLOW;
               end else begin
                  rsp_in.num_r = neg_ff ? 64'(0) - m_ff : m_ff;
                  rsp_in.den_r = div_res.quotient[62:0];
               end
            end
         end
         ST_DONE: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) req_ff <= req_data;
      p_ff <= p_in;
      q_ff <= q_in;
      d_ff <= d_in;
      m_ff <= m_in;
      e_ff <= e_in;
      g_ff <= g_in;
      neg_ff <= neg_in;
      mstep_ff <= mstep_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
